// ===== sv/brfd_pkg.sv =====
// brfd_pkg: types and constants for the backend reply frame deframer
// used by brfd_parse and backend_reply_frame_deframer; no dependencies
package brfd_pkg;

    localparam logic [31:0] TYPE_HELLO     = 32'd1001;
    localparam logic [31:0] TYPE_UDP       = 32'd1002;
    localparam logic [31:0] TYPE_HEARTBEAT = 32'd1004;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1500;

    // byte_index value at the last byte of a 32-bit word
    localparam logic [1:0] LAST_WORD_BYTE = 2'd3;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_PORT    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_FAULT   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HELLO     = 3'd0,
        KIND_HEARTBEAT = 3'd1,
        KIND_UDP_HDR   = 3'd2,
        KIND_PAYLOAD   = 3'd3,
        KIND_BAD_TYPE  = 3'd4,
        KIND_OVERSIZE  = 3'd5
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] dest_addr;
        logic [15:0] udp_port;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

// ===== sv/brfd_parse.sv =====
// brfd_parse: frame parser state and the one-byte state update
// depends on brfd_pkg; stepped by the top level once per item
module brfd_parse
    import brfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_max_len,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_byte_index, n_byte_index;
    logic [31:0] r_word_shift, n_word_shift;
    logic [31:0] r_held_addr, n_held_addr;
    logic [15:0] r_held_port, n_held_port;
    logic [15:0] r_bytes_rem, n_bytes_rem;

    logic [31:0] word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_byte_index <= '0;
            r_word_shift <= '0;
            r_held_addr  <= '0;
            r_held_port  <= '0;
            r_bytes_rem  <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_word_shift <= n_word_shift;
            r_held_addr  <= n_held_addr;
            r_held_port  <= n_held_port;
            r_bytes_rem  <= n_bytes_rem;
        end
    end

    // little-endian: the new byte lands on top
    assign word = {i_data_byte, r_word_shift[31:8]};

    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_word_shift = r_word_shift;
        n_held_addr  = r_held_addr;
        n_held_port  = r_held_port;
        n_bytes_rem  = r_bytes_rem;
        o_res        = '0;

        if (i_cmd) begin
            n_phase      = PH_TYPE;
            n_byte_index = '0;
            n_word_shift = '0;
            n_held_addr  = '0;
            n_held_port  = '0;
            n_bytes_rem  = '0;
        end else begin
            case (r_phase)
                PH_PAYLOAD: begin
                    n_bytes_rem        = r_bytes_rem - 16'd1;
                    o_res.valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = i_data_byte;
                    o_res.last         = (n_bytes_rem == '0);
                    if (n_bytes_rem == '0) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE, PH_ADDR, PH_PORT, PH_LEN: begin
                    n_word_shift = word;
                    if (r_byte_index != LAST_WORD_BYTE) begin
                        n_byte_index = r_byte_index + 2'd1;
                    end else begin
                        n_byte_index = '0;
                        case (r_phase)
                            PH_TYPE: begin
                                if (word == TYPE_HELLO) begin
                                    o_res.valid = 1'b1;
                                    o_res.kind  = KIND_HELLO;
                                end else if (word == TYPE_HEARTBEAT) begin
                                    o_res.valid = 1'b1;
                                    o_res.kind  = KIND_HEARTBEAT;
                                end else if (word == TYPE_UDP) begin
                                    n_phase = PH_ADDR;
                                end else begin
                                    n_phase     = PH_FAULT;
                                    o_res.valid = 1'b1;
                                    o_res.kind  = KIND_BAD_TYPE;
                                end
                            end
                            PH_ADDR: begin
                                n_held_addr = word;
                                n_phase     = PH_PORT;
                            end
                            PH_PORT: begin
                                n_held_port = word[15:0];
                                n_phase     = PH_LEN;
                            end
                            default: begin
                                // full 32-bit length against the limit
                                o_res.valid = 1'b1;
                                if (word > {16'd0, i_max_len}) begin
                                    n_phase    = PH_FAULT;
                                    o_res.kind = KIND_OVERSIZE;
                                end else begin
                                    o_res.kind           = KIND_UDP_HDR;
                                    o_res.dest_addr      = r_held_addr;
                                    o_res.udp_port       = r_held_port;
                                    o_res.payload_length = word[15:0];
                                    if (word == '0) begin
                                        n_phase    = PH_TYPE;
                                        o_res.last = 1'b1;
                                    end else begin
                                        n_phase     = PH_PAYLOAD;
                                        n_bytes_rem = word[15:0];
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    // faulted: wait for restart
                end
            endcase
        end
    end

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_cmd |=> r_phase == PH_TYPE && r_byte_index == '0)
        else $error("restart did not clear parser");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_rem != '0)
        else $error("payload phase with no bytes remaining");

endmodule

// ===== sv/backend_reply_frame_deframer.sv =====
// backend_reply_frame_deframer: top level, input and result registers, limit register
// depends on brfd_pkg and brfd_parse
//
// Takes the backend byte stream one item per clock and sustains one item per
// cycle while the receiver does not stall: each byte needs only the parser state update in
// brfd_parse, which sits between an input register and a result register, so
// an item's result is presented from the result register. The input side
// keeps accepting while a result waits, stalling only when both registers
// hold an item. Hello and heartbeat frames give one item each, an outbound udp
// frame gives a header item then one item per payload byte (last flagged), and
// a bad type or oversize length gives a fault item after which data is
// dropped until a restart item (cmd = 1). The max payload length register
// resets to 1500 and should be written only while the block is idle.
module backend_reply_frame_deframer
    import brfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_dest_addr,
    output logic [15:0] o_udp_port,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_max_len;

    logic        can_move;
    t_result     res;

    assign can_move    = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !can_move;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_data_byte;
        end
    end

    brfd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_in_valid && can_move),
        .i_cmd       (r_in_cmd),
        .i_data_byte (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_move) begin
            r_out_valid <= r_in_valid && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_move) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_dest_addr      = r_out.dest_addr;
    assign o_udp_port       = r_out.udp_port;
    assign o_payload_length = r_out.payload_length;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_last           = r_out.last;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> r_out.kind == KIND_PAYLOAD || r_out.kind == KIND_UDP_HDR)
        else $error("last flag on a non-udp item");

    a_zero_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_out.kind == KIND_UDP_HDR && o_payload_length == '0 |-> o_last)
        else $error("zero-length header without last");

endmodule

// ===== sim/tb_backend_reply_frame_deframer.sv =====
// tb_backend_reply_frame_deframer: self-checking testbench for the reply frame deframer
// feeds framed byte streams, predicts each event in a small scoreboard class and compares
// depends on brfd_pkg and backend_reply_frame_deframer
import brfd_pkg::*;

localparam logic CMD_DATA    = 1'b0;
localparam logic CMD_RESTART = 1'b1;

// a frame type with no meaning, handled as a bad type
localparam logic [31:0] TYPE_RESERVED = 32'd1003;

class reply_frame_tracker;
    t_phase      phase;
    logic [1:0]  byte_pos;
    logic [31:0] word_acc;
    logic [31:0] held_addr;
    logic [15:0] held_port;
    logic [15:0] remaining;
    logic [15:0] max_len;
    t_result     expected_events[$];
    int unsigned mismatches;

    function new();
        max_len    = MAX_PAYLOAD_RESET;
        mismatches = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        phase     = PH_TYPE;
        byte_pos  = '0;
        word_acc  = '0;
        held_addr = '0;
        held_port = '0;
        remaining = '0;
    endfunction

    function void set_max_len(logic [15:0] value);
        max_len = value;
    endfunction

    function void push_event(t_kind kind, logic [31:0] addr, logic [15:0] port,
                             logic [15:0] len, logic [7:0] pbyte, logic last);
        t_result ev;
        ev.valid          = 1'b1;
        ev.kind           = kind;
        ev.dest_addr      = addr;
        ev.udp_port       = port;
        ev.payload_length = len;
        ev.payload_byte   = pbyte;
        ev.last           = last;
        expected_events.push_back(ev);
    endfunction

    // advance the deframer by one accepted item and queue the event it gives
    function void note_item(logic cmd, logic [7:0] data);
        if (cmd == CMD_RESTART) begin
            clear_frame();
            return;
        end
        if (phase == PH_PAYLOAD) begin
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) begin
                phase = PH_TYPE;
                push_event(KIND_PAYLOAD, '0, '0, '0, data, 1'b1);
            end else begin
                push_event(KIND_PAYLOAD, '0, '0, '0, data, 1'b0);
            end
            return;
        end
        // faulted: data is dropped
        if (phase != PH_TYPE && phase != PH_ADDR && phase != PH_PORT && phase != PH_LEN)
            return;
        word_acc = {data, word_acc[31:8]};
        if (byte_pos != LAST_WORD_BYTE) begin
            byte_pos = byte_pos + 2'd1;
            return;
        end
        byte_pos = '0;
        case (phase)
            PH_TYPE: begin
                if (word_acc == TYPE_HELLO) begin
                    push_event(KIND_HELLO, '0, '0, '0, '0, 1'b0);
                end else if (word_acc == TYPE_HEARTBEAT) begin
                    push_event(KIND_HEARTBEAT, '0, '0, '0, '0, 1'b0);
                end else if (word_acc == TYPE_UDP) begin
                    phase = PH_ADDR;
                end else begin
                    phase = PH_FAULT;
                    push_event(KIND_BAD_TYPE, '0, '0, '0, '0, 1'b0);
                end
            end
            PH_ADDR: begin
                held_addr = word_acc;
                phase     = PH_PORT;
            end
            PH_PORT: begin
                held_port = word_acc[15:0];
                phase     = PH_LEN;
            end
            default: begin
                // whole 32-bit length against the limit
                if (word_acc > {16'd0, max_len}) begin
                    phase = PH_FAULT;
                    push_event(KIND_OVERSIZE, '0, '0, '0, '0, 1'b0);
                end else if (word_acc == 32'd0) begin
                    phase = PH_TYPE;
                    push_event(KIND_UDP_HDR, held_addr, held_port, '0, '0, 1'b1);
                end else begin
                    remaining = word_acc[15:0];
                    phase     = PH_PAYLOAD;
                    push_event(KIND_UDP_HDR, held_addr, held_port, word_acc[15:0], '0, 1'b0);
                end
            end
        endcase
    endfunction

    function void check_event(t_result got);
        t_result want;
        if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d addr %h port %h len %0d byte %h last %b",
                         got.kind, got.dest_addr, got.udp_port, got.payload_length,
                         got.payload_byte, got.last);
            return;
        end
        want = expected_events.pop_front();
        if (got.kind !== want.kind || got.dest_addr !== want.dest_addr
                || got.udp_port !== want.udp_port
                || got.payload_length !== want.payload_length
                || got.payload_byte !== want.payload_byte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected kind %0d addr %h port %h len %0d byte %h last %b",
                         want.kind, want.dest_addr, want.udp_port, want.payload_length,
                         want.payload_byte, want.last);
                $display("          actual   kind %0d addr %h port %h len %0d byte %h last %b",
                         got.kind, got.dest_addr, got.udp_port, got.payload_length,
                         got.payload_byte, got.last);
            end
        end
    endfunction
endclass

module tb_backend_reply_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int PHASE_COUNT     = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_cmd       = CMD_DATA;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_dest_addr;
    logic [15:0] o_udp_port;
    logic [15:0] o_payload_length;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    reply_frame_tracker frames;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    logic        rx_hold       = 1'b0;
    int          items_sent    = 0;
    int          items_ignored = 0;
    int          quiet_cycles  = 0;
    logic [15:0] limit_setting = MAX_PAYLOAD_RESET;

    backend_reply_frame_deframer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_dest_addr      (o_dest_addr),
        .o_udp_port       (o_udp_port),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.valid          = 1'b1;
            seen.kind           = t_kind'(o_kind);
            seen.dest_addr      = o_dest_addr;
            seen.udp_port       = o_udp_port;
            seen.payload_length = o_payload_length;
            seen.payload_byte   = o_payload_byte;
            seen.last           = o_last;
            frames.check_event(seen);
        end
        if (i_rst_n && i_valid && !o_stall)
            frames.note_item(i_cmd, i_data_byte);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_word(input logic [31:0] word);
        for (int i = 0; i < 4; i++) send_item(CMD_DATA, word[8*i +: 8]);
    endtask

    task automatic send_restart();
        send_item(CMD_RESTART, 8'($urandom));
    endtask

    // bytes sent while the parser is faulted
    task automatic send_ignored(input int count);
        repeat (count) begin
            send_item(CMD_DATA, 8'($urandom));
            items_ignored++;
        end
    endtask

    task automatic send_udp(input logic [31:0] addr, input logic [31:0] port,
                            input logic [31:0] len, input int payload_count);
        send_word(TYPE_UDP);
        send_word(addr);
        send_word(port);
        send_word(len);
        repeat (payload_count) send_item(CMD_DATA, 8'($urandom));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (frames.expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        frames.set_max_len(value);
        limit_setting = value;
    endtask

    task automatic hold_off();
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic directed_frames();
        send_word(TYPE_HELLO);
        send_word(TYPE_HEARTBEAT);
        // zero length: header alone, flagged last; upper port bits dropped
        send_udp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0);
        send_udp(32'h0000_0000, 32'h0001_ABCD, 32'd2, 0);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_word(TYPE_RESERVED);
        send_ignored(3);
        send_restart();
        send_udp($urandom, $urandom, {16'd0, limit_setting} + 32'd1, 0);
        send_restart();
        // low half zero, still oversize
        send_udp($urandom, $urandom, 32'h0001_0000, 0);
        send_restart();
        send_word(32'hFFFF_FFFF);
        send_restart();
        send_word(32'h0000_0000);
        send_restart();
        // restart in the middle of a type word, then of a payload
        send_item(CMD_DATA, TYPE_HELLO[7:0]);
        send_item(CMD_DATA, TYPE_HELLO[15:8]);
        send_restart();
        send_word(TYPE_HELLO);
        send_udp($urandom, $urandom, 32'd5, 2);
        send_restart();
        send_word(TYPE_HEARTBEAT);
        send_item(CMD_RESTART, 8'h00);
        send_item(CMD_RESTART, 8'hFF);
    endtask

    // a length right at the limit, then one just past it
    task automatic limit_edges();
        int count;
        count = (limit_setting <= 16'd64) ? int'(limit_setting) : 3;
        send_udp($urandom, $urandom, {16'd0, limit_setting}, count);
        if (count != int'(limit_setting)) send_restart();
        send_udp($urandom, $urandom, {16'd0, limit_setting} + 32'd1, 0);
        send_ignored(2);
        send_restart();
    endtask

    task automatic random_frame();
        int          pick;
        int          len_cap;
        int          len;
        logic [31:0] word;
        pick    = $urandom_range(99);
        len_cap = (limit_setting < 16'd24) ? int'(limit_setting) : 24;
        if ($urandom_range(15) == 0) send_restart();
        if (pick < 18) begin
            send_word(TYPE_HELLO);
        end else if (pick < 34) begin
            send_word(TYPE_HEARTBEAT);
        end else if (pick < 74) begin
            len = $urandom_range(len_cap, 0);
            if ($urandom_range(19) == 0)
                len = $urandom_range((limit_setting < 16'd300) ? int'(limit_setting) : 300, 0);
            send_udp($urandom, $urandom, len, len);
        end else if (pick < 80) begin
            if ($urandom_range(1))
                word = {16'd0, limit_setting} + 32'($urandom_range(40, 1));
            else
                word = $urandom | 32'h0001_0000;
            send_udp($urandom, $urandom, word, 0);
            if ($urandom_range(1)) send_ignored($urandom_range(6, 1));
            send_restart();
        end else if (pick < 86) begin
            word = ($urandom_range(3) == 0) ? TYPE_RESERVED : $urandom;
            send_word(word);
            if ($urandom_range(1)) send_ignored($urandom_range(6, 1));
            send_restart();
        end else if (pick < 93) begin
            // frame cut short by a restart
            if (len_cap < 2 || $urandom_range(1)) begin
                send_word(TYPE_UDP);
                repeat ($urandom_range(11)) send_item(CMD_DATA, 8'($urandom));
            end else begin
                send_udp($urandom, $urandom, len_cap, $urandom_range(len_cap - 1, 0));
            end
            send_restart();
        end else begin
            repeat ($urandom_range(8, 1)) send_item(CMD_DATA, 8'($urandom));
            send_restart();
        end
    endtask

    initial begin
        int target;
        frames = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_frames();
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 87;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 87;
                end
                default: begin
                    tx_idle_pct  = 33;
                    rx_stall_pct = 33;
                end
            endcase
            case (p)
                1: write_limit(16'd0);
                2: write_limit(16'hFFFF);
                3: write_limit(16'd16);
                4: write_limit(16'($urandom_range(65535)));
                5: write_limit(16'($urandom_range(64, 1)));
                default: ;
            endcase
            // long receiver hold-off while items keep coming
            if (p == 0) fork hold_off(); join_none
            limit_edges();
            target = items_sent - items_ignored + ITEMS_PER_PHASE;
            while (items_sent - items_ignored < target) random_frame();
        end
        settle();
        if (frames.mismatches == 0 && frames.expected_events.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/brfd_pkg.sv
sv/brfd_parse.sv
sv/backend_reply_frame_deframer.sv
sim/tb_backend_reply_frame_deframer.sv
